### hdl/sequenced_frame_packetizer_defines.svh
// Assertion macros for the packetizer RTL, used by sfp_queue.
// Expects clk and rst_n in the scope of every use.
`ifndef SEQUENCED_FRAME_PACKETIZER_DEFINES_SVH
`define SEQUENCED_FRAME_PACKETIZER_DEFINES_SVH

// Condition holds at every edge outside reset.
`define SFP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds after the antecedent, as a non-overlapping implication.
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sfp_pkg.sv
// Package for the sequenced frame packetizer: register codes, header modes,
// configuration and queue entry types. No dependencies.
package sfp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam logic [2:0] CFG_HEADER_MODE    = 3'd0;
    localparam logic [2:0] CFG_PAYLOAD_BYTES  = 3'd1;
    localparam logic [2:0] CFG_SOURCE_ADDRESS = 3'd2;
    localparam logic [2:0] CFG_DEST_ADDRESS   = 3'd3;
    localparam logic [2:0] CFG_FRAME_TYPE     = 3'd4;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SEQ  = 2'd1;
    localparam logic [1:0] MODE_SIZE = 2'd2;
    localparam logic [1:0] MODE_CRC  = 2'd3;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [13:0] PAYLOAD_RESET = 14'd1024;

    typedef struct packed {
        logic [1:0]  header_mode;
        logic [13:0] payload_bytes;
        logic [47:0] source_address;
        logic [47:0] dest_address;
        logic [15:0] frame_type;
    } cfg_t;

    // One classified input byte, as handed from the front to the back
    typedef struct packed {
        logic [7:0]  data;
        logic        open;      // header goes out before this byte
        logic [1:0]  hmode;     // header mode when this byte was pushed
        logic [31:0] seq;
        logic [13:0] size;
        logic        last;      // last payload byte of its packet
        logic        trailer;   // last byte and CRC trailer follows
        logic [31:0] crc;       // CRC up to this byte, already inverted
    } job_t;

endpackage

### hdl/sfp_queue.sv
// Small request queue between the front and back parts.
// Depends on sfp_pkg and sequenced_frame_packetizer_defines.svh.
`include "sequenced_frame_packetizer_defines.svh"

module sfp_queue
    import sfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam logic [QUEUE_CW-1:0] COUNT_FULL = QUEUE_CW'(QUEUE_DEPTH);

    job_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign full  = (count_reg == COUNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SFP_ASSERT_ALWAYS(a_no_push_full, !(push && full), "push into full queue")
    `SFP_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "pop from empty queue")
    `SFP_ASSERT_NEXT(a_count_up, (push && !pop), (count_reg == $past(count_reg) + 1'b1), "count lost a push")

endmodule

### hdl/sfp_front.sv
// Front part: accepts input bytes, opens packets, tracks sequence number,
// packet fill and CRC, and pushes classified requests. Depends on sfp_pkg.
module sfp_front
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic [19:0] bytes_left,
    input  logic        full,
    output logic        push,
    output job_t        push_job
);

    logic [31:0] seq_reg;
    logic [31:0] seq_next;
    logic [13:0] to_go_reg;
    logic [13:0] to_go_next;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    logic        opening;
    logic [13:0] full_size;
    logic [19:0] left_fix;
    logic [13:0] size;
    logic [31:0] crc_start;
    logic [13:0] to_go_start;

    function automatic logic [31:0] crc_byte(input logic [31:0] acc_in,
                                             input logic [7:0]  b);
        logic [31:0] acc;
        acc = acc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    assign data_ready = !full;
    assign push       = data_valid && data_ready;

    always_comb
    begin
        opening     = (to_go_reg == 14'd0);
        full_size   = (cfg.payload_bytes == 14'd0) ? 14'd1 : cfg.payload_bytes;
        left_fix    = (bytes_left == 20'd0) ? 20'd1 : bytes_left;
        size        = (left_fix < {6'd0, full_size}) ? left_fix[13:0] : full_size;
        crc_start   = opening ? ALL_ONES : crc_reg;
        to_go_start = opening ? size : to_go_reg;

        seq_next = seq_reg;
        if (opening && cfg.header_mode != MODE_NONE)
        begin
            seq_next = (seq_reg == ALL_ONES) ? 32'd1 : seq_reg + 32'd1;
        end
        crc_next   = crc_byte(crc_start, data_byte);
        to_go_next = to_go_start - 14'd1;

        push_job.data    = data_byte;
        push_job.open    = opening;
        push_job.hmode   = cfg.header_mode;
        push_job.seq     = seq_next;
        push_job.size    = size;
        push_job.last    = (to_go_next == 14'd0);
        push_job.trailer = (to_go_next == 14'd0) && (cfg.header_mode == MODE_CRC);
        push_job.crc     = crc_next ^ ALL_ONES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= '0;
            to_go_reg <= '0;
            crc_reg   <= ALL_ONES;
        end
        else if (push)
        begin
            seq_reg   <= seq_next;
            to_go_reg <= to_go_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

### hdl/sfp_back.sv
// Back (uses sfp_pkg): walks each queued request through header, payload
// byte and trailer into the output register, one byte per unstalled cycle.
module sfp_back
    import sfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  job_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_byte,
    output logic       packet_end,
    output logic       run_last
);

    localparam logic [5:0] STEP_SRC0    = 6'd0;
    localparam logic [5:0] STEP_TYPE_LO = 6'd13;
    localparam logic [5:0] STEP_SEQ3    = 6'd21;
    localparam logic [5:0] STEP_DATA    = 6'd26;
    localparam logic [5:0] STEP_LAST    = 6'd34;

    logic [5:0]       step_reg;
    logic [5:0]       step_next;
    logic             started_reg;
    logic             started_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       byte_reg;
    logic             end_reg;
    logic             last_reg;

    logic [5:0]       cur;
    logic [5:0]       adv;
    logic             load;
    logic             done;
    logic             pend;
    logic [34:0][7:0] fb;
    logic [31:0]      size32;

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign packet_end   = end_reg;
    assign run_last     = last_reg;

    always_comb
    begin
        size32 = {18'd0, head.size};
        for (int k = 0; k < 6; k++)
        begin
            fb[k]     = cfg.source_address[8*(5-k) +: 8];
            fb[6 + k] = cfg.dest_address[8*(5-k) +: 8];
        end
        fb[12] = cfg.frame_type[15:8];
        fb[13] = cfg.frame_type[7:0];
        for (int k = 0; k < 4; k++)
        begin
            fb[14 + k] = 8'hFF;
            fb[18 + k] = head.seq[8*k +: 8];
            fb[22 + k] = size32[8*k +: 8];
            fb[27 + k] = head.crc[8*k +: 8];
            fb[31 + k] = 8'h00;
        end
        fb[26] = head.data;
    end

    always_comb
    begin
        load = !empty && (!valid_reg || result_ready);
        cur  = started_reg ? step_reg : (head.open ? STEP_SRC0 : STEP_DATA);
        done = ((cur == STEP_DATA) && !head.trailer) || (cur == STEP_LAST);
        pend = ((cur == STEP_DATA) && head.last && !head.trailer) || (cur == STEP_LAST);

        // Skip the optional header words that this packet's mode leaves out
        if ((cur == STEP_TYPE_LO) && (head.hmode == MODE_NONE))
        begin
            adv = STEP_DATA;
        end
        else if ((cur == STEP_SEQ3) && (head.hmode == MODE_SEQ))
        begin
            adv = STEP_DATA;
        end
        else
        begin
            adv = cur + 6'd1;
        end

        pop          = load && done;
        step_next    = step_reg;
        started_next = started_reg;
        valid_next   = valid_reg;
        if (load)
        begin
            valid_next   = 1'b1;
            started_next = !done;
            step_next    = adv;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= fb[cur];
            end_reg  <= pend;
            last_reg <= done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_SRC0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

endmodule

### hdl/sequenced_frame_packetizer.sv
// An accepted request is queued, then its first byte is loaded into the output
// register. Throughput: one output byte per cycle from the back sequencer while
// the output is ready; a request yields 1 to 35 bytes there (14 header, 0/8/12
// header words, 1 data, 8 trailer), and inputs keep flowing one per cycle while the
// 4-entry queue has room. Reset: registers to defaults, sequence 0, no packet open,
// CRC all ones, queue and output empty; no clearing pass, ready right after reset.
// Depends on sfp_pkg, sfp_queue, sfp_front and sfp_back.
module sequenced_frame_packetizer
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    // input byte channel
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic [19:0] bytes_left,
    // framed output channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  out_byte,
    output logic        packet_end,
    output logic        run_last
);

    cfg_t cfg_reg;
    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t push_job;
    job_t head;

    // Take every config request at once; writes must come only when idle (unenforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mode    <= MODE_NONE;
            cfg_reg.payload_bytes  <= PAYLOAD_RESET;
            cfg_reg.source_address <= '0;
            cfg_reg.dest_address   <= '0;
            cfg_reg.frame_type     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER_MODE:    cfg_reg.header_mode    <= cfg_data[1:0];
                CFG_PAYLOAD_BYTES:  cfg_reg.payload_bytes  <= cfg_data[13:0];
                CFG_SOURCE_ADDRESS: cfg_reg.source_address <= cfg_data;
                CFG_DEST_ADDRESS:   cfg_reg.dest_address   <= cfg_data;
                CFG_FRAME_TYPE:     cfg_reg.frame_type     <= cfg_data[15:0];
                default:            cfg_reg                <= cfg_reg; // drop unknown index
            endcase
        end
    end

    // Front: classify each byte and hold packet, sequence and CRC state
    sfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .bytes_left (bytes_left),
        .full       (full),
        .push       (push),
        .push_job   (push_job)
    );

    // Queue: decouple the front from back-pressure on the output
    sfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    // Back: expand each request into header, payload and trailer bytes
    sfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .packet_end   (packet_end),
        .run_last     (run_last)
    );

endmodule

### sim/frame_stream_monitor.sv
`timescale 1ns / 100ps
// Frame stream monitor for the sequenced frame packetizer testbench: follows register
// writes and input requests, predicts the framed byte stream and compares it with the
// output channel. Depends on sfp_pkg.
module frame_stream_monitor
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        data_valid,
    input  logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic [19:0] bytes_left,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [7:0]  out_byte,
    input  logic        packet_end,
    input  logic        run_last,
    output int          mismatch_count,
    output int          bytes_owed
);

    typedef struct packed {
        logic [7:0] value;
        logic       pkt_end;
        logic       run_end;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];

    cfg_t        regs;
    logic [31:0] seq_number;
    logic [13:0] payload_left;
    logic [31:0] crc_acc;

    // Reflected CRC-32, one byte folded in
    function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] v, input logic e);
        frame_byte_t entry;
        entry.value   = v;
        entry.pkt_end = e;
        entry.run_end = 1'b0;
        expected_bytes = {expected_bytes, entry};
    endtask

    task automatic push_le32(input logic [31:0] w, input logic end_on_last);
        for (int k = 0; k < 4; k++)
            push_byte(w[8*k +: 8], end_on_last && (k == 3));
    endtask

    // Expected bytes for one accepted payload byte
    task automatic predict_frame(input logic [7:0] data, input logic [19:0] left);
        logic [13:0] full;
        logic [19:0] claim;
        logic [13:0] size;
        frame_byte_t tail;
        if (payload_left == '0)
        begin
            full  = (regs.payload_bytes == '0) ? 14'd1 : regs.payload_bytes;
            claim = (left == '0) ? 20'd1 : left;
            size  = (claim < {6'd0, full}) ? claim[13:0] : full;
            payload_left = size;
            crc_acc = ALL_ONES;
            for (int k = 5; k >= 0; k--)
                push_byte(regs.source_address[8*k +: 8], 1'b0);
            for (int k = 5; k >= 0; k--)
                push_byte(regs.dest_address[8*k +: 8], 1'b0);
            push_byte(regs.frame_type[15:8], 1'b0);
            push_byte(regs.frame_type[7:0], 1'b0);
            if (regs.header_mode != MODE_NONE)
            begin
                seq_number = (seq_number == ALL_ONES) ? 32'd1 : seq_number + 32'd1;
                push_le32(ALL_ONES, 1'b0);
                push_le32(seq_number, 1'b0);
                if (regs.header_mode inside {MODE_SIZE, MODE_CRC})
                    push_le32({18'd0, size}, 1'b0);
            end
        end
        crc_acc = crc32_fold(crc_acc, data);
        payload_left = payload_left - 14'd1;
        if (payload_left != '0)
            push_byte(data, 1'b0);
        else if (regs.header_mode == MODE_CRC)
        begin
            push_byte(data, 1'b0);
            push_le32(~crc_acc, 1'b0);
            push_le32(32'd0, 1'b1);
        end
        else
            push_byte(data, 1'b1);
        // Mark the final byte of this request
        tail = expected_bytes[$];
        tail.run_end = 1'b1;
        expected_bytes[expected_bytes.size() - 1] = tail;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_byte_t want;
        if (!rst_n)
        begin
            regs.header_mode    = MODE_NONE;
            regs.payload_bytes  = PAYLOAD_RESET;
            regs.source_address = '0;
            regs.dest_address   = '0;
            regs.frame_type     = '0;
            seq_number     = '0;
            payload_left   = '0;
            crc_acc        = ALL_ONES;
            mismatch_count = 0;
            bytes_owed     = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEADER_MODE:    regs.header_mode    = cfg_data[1:0];
                    CFG_PAYLOAD_BYTES:  regs.payload_bytes  = cfg_data[13:0];
                    CFG_SOURCE_ADDRESS: regs.source_address = cfg_data;
                    CFG_DEST_ADDRESS:   regs.dest_address   = cfg_data;
                    CFG_FRAME_TYPE:     regs.frame_type     = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (data_valid && data_ready)
                predict_frame(data_byte, bytes_left);
            if (result_valid && result_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected byte %02h end %0b last %0b", $time,
                                 out_byte, packet_end, run_last);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (want.value !== out_byte || want.pkt_end !== packet_end ||
                        want.run_end !== run_last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: expected byte %02h end %0b last %0b, got %02h %0b %0b",
                                     $time, want.value, want.pkt_end, want.run_end,
                                     out_byte, packet_end, run_last);
                    end
                end
            end
            bytes_owed = expected_bytes.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Top of the sequenced frame packetizer testbench: clock, reset, register writes,
// payload requests and the verdict. Depends on sfp_pkg, the packetizer RTL and
// frame_stream_monitor, which does all prediction and checking.
module testbench;
    import sfp_pkg::*;

    // Generous bound: worst case is ~35 bytes per request with a receiver stalling
    // 78% of the time, a few hundred requests in all.
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        data_valid;
    logic        data_ready;
    logic [7:0]  data_byte;
    logic [19:0] bytes_left;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        packet_end;
    logic        run_last;

    int mismatch_count;
    int bytes_owed;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int current_payload = 1024;

    sequenced_frame_packetizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .bytes_left   (bytes_left),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .packet_end   (packet_end),
        .run_last     (run_last)
    );

    frame_stream_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_valid     (data_valid),
        .data_ready     (data_ready),
        .data_byte      (data_byte),
        .bytes_left     (bytes_left),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .out_byte       (out_byte),
        .packet_end     (packet_end),
        .run_last       (run_last),
        .mismatch_count (mismatch_count),
        .bytes_owed     (bytes_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the output channel at random; the rate follows the current idling phase.
    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one payload request and hold it until accepted. Valid stays high into
    // the next request unless a random gap drops it first, so valid is never
    // lowered and raised within one step.
    task automatic send_request(input logic [7:0] d, input logic [19:0] l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= d;
        bytes_left <= l;
        do
            @(posedge clk);
        while (!data_ready);
    endtask

    // Drop valid and wait until every predicted byte has come out. Sample at the
    // falling edge so the monitor's update at the rising edge has settled.
    task automatic drain;
        data_valid <= 1'b0;
        do
            @(negedge clk);
        while (bytes_owed != 0);
        @(posedge clk);
    endtask

    // Hold one register write until accepted; the caller drops valid afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Reprogram all registers once the block has gone quiet.
    task automatic apply_settings(input logic [1:0] mode, input logic [13:0] payload,
                                  input logic [47:0] src, input logic [47:0] dst,
                                  input logic [15:0] ftype);
        drain();
        write_reg(CFG_HEADER_MODE, {46'd0, mode});
        write_reg(CFG_PAYLOAD_BYTES, {34'd0, payload});
        write_reg(CFG_SOURCE_ADDRESS, src);
        write_reg(CFG_DEST_ADDRESS, dst);
        write_reg(CFG_FRAME_TYPE, {32'd0, ftype});
        cfg_valid <= 1'b0;
        current_payload = int'(payload);
    endtask

    // Mostly well-formed blocks with random content; the rest are stray requests
    // with arbitrary tags and blocks that stop short of what they promised.
    task automatic random_blocks(input int n_requests);
        int sent;
        int full;
        int max_len;
        int len;
        int claim;
        int kind;
        sent = 0;
        full = (current_payload == 0) ? 1 : current_payload;
        max_len = (full > 12) ? 40 : 3 * full + 2;
        while (sent < n_requests)
        begin
            kind = $urandom_range(9);
            len  = $urandom_range(1, max_len);
            if (kind == 0)
            begin
                len = 1;
                if ($urandom_range(3) == 0)
                    claim = $urandom_range(0, 20'hFFFFF);
                else
                    claim = $urandom_range(0, 2 * max_len);
            end
            else if (kind == 1)
                claim = len + $urandom_range(1, 8);
            else
                claim = len;
            for (int k = 0; k < len; k++)
                send_request(8'($urandom_range(255)), 20'(claim - k));
            sent += len;
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_HEADER_MODE;
        cfg_data   <= '0;
        data_valid <= 1'b0;
        data_byte  <= '0;
        bytes_left <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: sender idles lightly, receiver heavily.
        send_idle_pct = 10;
        recv_idle_pct = 78;
        apply_settings(MODE_CRC, 14'd4, 48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        // short block: one packet smaller than the full size
        send_request(8'h00, 20'd3);
        send_request(8'hFF, 20'd2);
        send_request(8'h5A, 20'd1);
        // exact multiple of the packet size: last packet is full
        for (int k = 0; k < 8; k++)
            send_request(8'(k * 37), 20'(8 - k));
        // zero tag counts as one byte
        send_request(8'hA5, 20'd0);
        // largest tag opens a full packet; tags inside it are ignored
        send_request(8'h11, 20'hFFFFF);
        send_request(8'h22, 20'd1);
        send_request(8'h33, 20'd0);
        send_request(8'h44, 20'd7);
        // zero packet size acts as one, under every header mode
        apply_settings(MODE_NONE, 14'd0, 48'hFFFF_FFFF_FFFF, 48'h0, 16'h8100);
        send_request(8'h81, 20'd9);
        apply_settings(MODE_SEQ, 14'd0, 48'hFFFF_FFFF_FFFF, 48'h0, 16'h8100);
        send_request(8'h7E, 20'd9);
        apply_settings(MODE_SIZE, 14'd0, 48'hFFFF_FFFF_FFFF, 48'h0, 16'h8100);
        send_request(8'hC3, 20'd9);
        apply_settings(MODE_CRC, 14'd0, 48'hFFFF_FFFF_FFFF, 48'h0, 16'h8100);
        send_request(8'h3C, 20'd9);
        // leave a CRC-mode packet open so the next phase closes it under mode none
        apply_settings(MODE_CRC, 14'd3, 48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 16'h88B5);
        send_request(8'hDE, 20'd5);
        send_request(8'hAD, 20'd4);

        apply_settings(MODE_NONE, 14'd5, 48'({$urandom(), $urandom()}),
                       48'({$urandom(), $urandom()}), 16'($urandom()));
        random_blocks(50);

        // Swap the idling: sender stalls heavily, receiver lightly.
        send_idle_pct = 78;
        recv_idle_pct = 10;
        apply_settings(MODE_CRC, 14'h3FFF, 48'hFFFF_FFFF_FFFF, 48'h0, 16'h0);
        random_blocks(50);

        // No idling on either side from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(MODE_SIZE, 14'd3, 48'({$urandom(), $urandom()}),
                       48'({$urandom(), $urandom()}), 16'($urandom()));
        random_blocks(50);
        apply_settings(MODE_SEQ, 14'd1, 48'({$urandom(), $urandom()}),
                       48'({$urandom(), $urandom()}), 16'($urandom()));
        random_blocks(50);

        // Let the tail flush and catch any stray bytes.
        drain();
        repeat (40) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
